@@ design/jse_pkg.sv @@
// Shared types and constants for the JSON string escaper.
// Holds the job descriptor passed from the decoder to the serializer.
// No dependencies.
package jse_pkg;

    localparam int JOB_BYTES   = 6;
    localparam int JOB_IDX_W   = $clog2(JOB_BYTES);
    localparam int JOB_CNT_W   = $clog2(JOB_BYTES + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_FF     = 8'h0C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CTRL_LIMIT  = 8'd32;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LC_B   = 8'h62;
    localparam logic [7:0] CHAR_LC_T   = 8'h74;
    localparam logic [7:0] CHAR_LC_N   = 8'h6E;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;
    localparam logic [7:0] CHAR_LC_R   = 8'h72;
    localparam logic [7:0] CHAR_LC_U   = 8'h75;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h57;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    typedef struct packed {
        logic [JOB_CNT_W-1:0]      count;
        logic                      bad;
        logic [JOB_BYTES-1:0][7:0] bytes;
    } t_job;

endpackage

@@ design/jse_front.sv @@
// Decoder front end: tracks string framing, validates UTF-8 and builds
// at most one output job per accepted item. Depends on jse_pkg.
module jse_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_data_byte,
    input  logic             i_full,
    output logic             o_in_stall,
    output logic             o_push,
    output jse_pkg::t_job    o_job
);

    localparam int CntW = jse_pkg::JOB_CNT_W;

    logic        r_in_string, n_in_string;
    logic        r_error, n_error;
    logic [1:0]  r_bse, n_bse;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [23:0] r_held, n_held;
    logic        accept;
    logic        raise_err;
    jse_pkg::t_job job;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'b0, v};
        return (v < 4'd10) ? jse_pkg::CHAR_ZERO + w : jse_pkg::HEX_ALPHA_BASE + w;
    endfunction

    function automatic jse_pkg::t_job two_byte(input logic [7:0] c);
        jse_pkg::t_job j;
        j = '0;
        j.count    = CntW'(2);
        j.bytes[0] = jse_pkg::CHAR_BSLASH;
        j.bytes[1] = c;
        return j;
    endfunction

    function automatic jse_pkg::t_job ascii_job(input logic [7:0] c);
        jse_pkg::t_job j;
        j = '0;
        case (c)
            jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_QUOTE: j = two_byte(c);
            jse_pkg::CHAR_BS:  j = two_byte(jse_pkg::CHAR_LC_B);
            jse_pkg::CHAR_TAB: j = two_byte(jse_pkg::CHAR_LC_T);
            jse_pkg::CHAR_LF:  j = two_byte(jse_pkg::CHAR_LC_N);
            jse_pkg::CHAR_FF:  j = two_byte(jse_pkg::CHAR_LC_F);
            jse_pkg::CHAR_CR:  j = two_byte(jse_pkg::CHAR_LC_R);
            default: begin
                if (c < jse_pkg::CTRL_LIMIT) begin
                    j.count    = CntW'(6);
                    j.bytes[0] = jse_pkg::CHAR_BSLASH;
                    j.bytes[1] = jse_pkg::CHAR_LC_U;
                    j.bytes[2] = jse_pkg::CHAR_ZERO;
                    j.bytes[3] = jse_pkg::CHAR_ZERO;
                    j.bytes[4] = hex_digit(c[7:4]);
                    j.bytes[5] = hex_digit(c[3:0]);
                end else begin
                    j.count    = CntW'(1);
                    j.bytes[0] = c;
                end
            end
        endcase
        return j;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        case (lead)
            8'hE0:   ok = (b >= 8'hA0);
            8'hED:   ok = (b <= 8'h9F);
            8'hF0:   ok = (b >= 8'h90);
            8'hF4:   ok = (b <= 8'h8F);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;

    always_comb begin
        n_in_string = r_in_string;
        n_error     = r_error;
        n_bse       = r_bse;
        n_seq_len   = r_seq_len;
        n_held      = r_held;
        raise_err   = 1'b0;
        job         = '0;
        unique case (i_opcode)
            jse_pkg::OP_START: begin
                n_in_string = 1'b1;
                n_error     = 1'b0;
                n_bse       = '0;
                n_seq_len   = '0;
                n_held      = '0;
                job.count    = CntW'(1);
                job.bytes[0] = jse_pkg::CHAR_QUOTE;
            end
            jse_pkg::OP_DATA: begin
                if (r_in_string && !r_error) begin
                    if (r_bse == 2'd0) begin
                        if (i_data_byte < 8'h80) begin
                            job = ascii_job(i_data_byte);
                        end else if (i_data_byte >= 8'hC2 && i_data_byte <= 8'hDF) begin
                            n_seq_len = jse_pkg::SEQ_LEN_2;
                            n_bse     = 2'd1;
                            n_held    = {16'b0, i_data_byte};
                        end else if (i_data_byte >= 8'hE0 && i_data_byte <= 8'hEF) begin
                            n_seq_len = jse_pkg::SEQ_LEN_3;
                            n_bse     = 2'd2;
                            n_held    = {16'b0, i_data_byte};
                        end else if (i_data_byte >= 8'hF0 && i_data_byte <= 8'hF4) begin
                            n_seq_len = jse_pkg::SEQ_LEN_4;
                            n_bse     = 2'd3;
                            n_held    = {16'b0, i_data_byte};
                        end else begin
                            raise_err = 1'b1;
                        end
                    end else if (i_data_byte[7:6] != 2'b10) begin
                        raise_err = 1'b1;
                    end else if (({1'b0, r_bse} + 3'd1 == r_seq_len) &&
                                 !second_ok(r_held[7:0], i_data_byte)) begin
                        raise_err = 1'b1;
                    end else if (r_bse != 2'd1) begin
                        n_bse  = r_bse - 2'd1;
                        n_held = {r_held[15:0], i_data_byte};
                    end else begin
                        n_bse     = '0;
                        n_seq_len = '0;
                        n_held    = '0;
                        case (r_seq_len)
                            jse_pkg::SEQ_LEN_2: begin
                                job.count    = CntW'(2);
                                job.bytes[0] = r_held[7:0];
                                job.bytes[1] = i_data_byte;
                            end
                            jse_pkg::SEQ_LEN_3: begin
                                job.count    = CntW'(3);
                                job.bytes[0] = r_held[15:8];
                                job.bytes[1] = r_held[7:0];
                                job.bytes[2] = i_data_byte;
                            end
                            default: begin
                                job.count    = CntW'(4);
                                job.bytes[0] = r_held[23:16];
                                job.bytes[1] = r_held[15:8];
                                job.bytes[2] = r_held[7:0];
                                job.bytes[3] = i_data_byte;
                            end
                        endcase
                    end
                end
            end
            jse_pkg::OP_END: begin
                if (r_in_string && !r_error) begin
                    if (r_bse != 2'd0) begin
                        raise_err = 1'b1;
                    end else begin
                        n_in_string  = 1'b0;
                        n_seq_len    = '0;
                        n_held       = '0;
                        job.count    = CntW'(1);
                        job.bytes[0] = jse_pkg::CHAR_QUOTE;
                    end
                end
            end
            default: ;
        endcase
        if (raise_err) begin
            n_in_string = 1'b0;
            n_error     = 1'b1;
            n_bse       = '0;
            n_seq_len   = '0;
            n_held      = '0;
            job         = '0;
            job.count   = CntW'(1);
            job.bad     = 1'b1;
        end
    end

    assign o_push = accept && (job.count != '0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_error     <= 1'b0;
            r_bse       <= '0;
            r_seq_len   <= '0;
            r_held      <= '0;
        end else if (accept) begin
            r_in_string <= n_in_string;
            r_error     <= n_error;
            r_bse       <= n_bse;
            r_seq_len   <= n_seq_len;
            r_held      <= n_held;
        end
    end

`ifndef SYNTHESIS
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.count != '0) && (o_job.count <= CntW'(jse_pkg::JOB_BYTES)))
        else $error("job with bad byte count");
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.bad) |=> (r_error && !r_in_string && r_bse == 2'd0))
        else $error("error did not close the string");
    a_bse_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bse != 2'd0) |-> ({1'b0, r_bse} < r_seq_len))
        else $error("continuation count exceeds sequence length");
`endif

endmodule

@@ design/jse_fifo.sv @@
// Short job queue between decoder and serializer.
// Depends on jse_pkg for the job type.
module jse_fifo #(
    parameter int Depth = jse_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jse_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output jse_pkg::t_job o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    jse_pkg::t_job   r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(Depth))
        else $error("queue count out of range");
`endif

endmodule

@@ design/jse_back.sv @@
// Serializer back end: walks the head job into the output register one byte per cycle
// while the output is not stalled. Depends on jse_pkg.
module jse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jse_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    output logic          o_bad_utf8
);

    localparam int IdxW = jse_pkg::JOB_IDX_W;
    localparam int CntW = jse_pkg::JOB_CNT_W;

    logic [IdxW-1:0] r_idx;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;
    logic            r_out_bad;
    logic            advance;
    logic            take;
    logic            is_last;

    assign advance = !r_out_valid || !i_out_stall;
    assign take    = advance && !i_empty;
    assign is_last = (CntW'(r_idx) + CntW'(1)) == i_head.count;
    assign o_pop   = take && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= !i_empty;
            end
            if (take) begin
                r_idx <= is_last ? '0 : r_idx + IdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= i_head.bytes[r_idx];
            r_out_last <= is_last;
            r_out_bad  <= i_head.bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_bad_utf8    = r_out_bad;

`ifndef SYNTHESIS
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_utf8) |-> (o_last_of_run && o_out_byte == 8'h00))
        else $error("error result malformed");
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (CntW'(r_idx) < i_head.count))
        else $error("byte index beyond job");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == '0))
        else $error("index left over with empty queue");
`endif

endmodule

@@ design/utf8_json_string_escaper_core.sv @@
// Path: an accepted item's job is written into the queue, then walked into the output
// register; results leave one byte per cycle unless the output stalls (up to six bytes).
// Throughput: one input item per cycle while results are single bytes and the output
// is free; with one byte out per cycle, escapes hold input back once the queue fills.
// Reset: synchronous, active low; clears string state, job queue and output valid.
module utf8_json_string_escaper_core #(
    parameter int QueueDepth = jse_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_bad_utf8
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    jse_pkg::t_job job;
    jse_pkg::t_job head;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_full      (full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_job       (job)
    );

    jse_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_bad_utf8    (o_bad_utf8)
    );

endmodule
